>>> rtl/gpts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpts_pkg
// Shared types and constants of the granular pitch and time shifter.
// ----------------------------------------------------------------------------
package gpts_pkg;

   localparam int unsigned BUFFER_DEPTH_DEF = 8192;
   localparam int unsigned GRAIN_LENGTH_DEF = 512;
   localparam int unsigned GRAIN_SLOTS_DEF  = 4;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned STEP_W      = 18;
   localparam int unsigned HOP_W       = 9;
   localparam int unsigned HOP_COUNT_W = 10;
   localparam int unsigned CSR_DATA_W  = 18;
   localparam int unsigned HANN_W      = 16;

   localparam longint unsigned Q30_ONE = 64'd1073741824;
   localparam longint unsigned PI_Q30  = 64'd3373259426;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_ENABLE    = 2'd0;
   localparam csr_index_type CSR_READ_STEP = 2'd1;
   localparam csr_index_type CSR_HOP       = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_OFFS,
      ST_REDUCE,
      ST_ADDR,
      ST_RD1,
      ST_RD2,
      ST_LERP,
      ST_WEIGHT,
      ST_ACC,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

>>> rtl/gpts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpts_if
// Sample channels: valid/ready handshake with a signed 16-bit word.
// ----------------------------------------------------------------------------
interface gpts_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] in_sample;
   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface gpts_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] out_sample;
   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface

>>> rtl/gpts_delay_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpts_delay_mem
// Circular sample store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gpts_delay_mem #(
   parameter int unsigned DEPTH = 8192,
   parameter int unsigned AW    = 13
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] store [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
      rd_data_ff <= store[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gpts_hann_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpts_hann_rom
// Hann window table, unsigned Q1.15, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module gpts_hann_rom #(
   parameter int unsigned GRAIN_LENGTH = 512,
   parameter int unsigned IW           = 9
) (
   input  logic          clock,
   input  logic [IW-1:0] rd_index,
   output logic [15:0]   rd_data
);
   import gpts_pkg::*;

   localparam longint unsigned GRAIN_DEN = GRAIN_LENGTH - 1;

   function automatic longint unsigned sine_q30(longint unsigned a);
      longint unsigned a2;
      longint unsigned t;
      a2 = (a * a) >> 30;
      t  = Q30_ONE - a2 / 110;
      t  = Q30_ONE - ((a2 * t) >> 30) / 72;
      t  = Q30_ONE - ((a2 * t) >> 30) / 42;
      t  = Q30_ONE - ((a2 * t) >> 30) / 20;
      t  = Q30_ONE - ((a2 * t) >> 30) / 6;
      return (a * t) >> 30;
   endfunction

   function automatic logic [15:0] hann_value(longint unsigned i);
      longint unsigned k;
      longint unsigned m;
      longint unsigned s;
      longint unsigned w;
      k = i;
      m = GRAIN_DEN - i;
      if (m < k) k = m;
      s = sine_q30((PI_Q30 * k) / GRAIN_DEN);
      w = (((s * s) >> 30) + 64'd16384) >> 15;
      if (w > 64'd32768) w = 64'd32768;
      return w[15:0];
   endfunction

   logic [15:0] rom [GRAIN_LENGTH];
   logic [15:0] rd_data_ff;

   for (genvar i = 0; i < GRAIN_LENGTH; i++) begin : g_rom
      localparam logic [15:0] W = hann_value(i);
      assign rom[i] = W;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom[rd_index];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/granular_pitch_time_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// granular_pitch_time_shifter
// Grain based pitch and time shifter on a circular sample store.
//
// Usage: one signed 16-bit word enters on req per audio sample and exactly
// one processed word leaves on rsp. Registers go in through the csr write
// port (0 enable, 1 read step Q2.16, 2 hop length); the user must write them
// only while the block is idle, as the block itself does not enforce it.
// With the effect off each word goes from IDLE through FINISH to DONE. With
// it on, each word walks the grain slots one after another, and each active
// grain takes two reads through the single store read port.
// Reset initialises all control state and the grain table; store entries not yet
// written read as zero by a fill mark, so no clearing pass is needed.
// A result waits in the output register while rsp stalls; the next word is
// accepted and processed meanwhile, and stops before its result if the
// output register is still full.
// ----------------------------------------------------------------------------
module granular_pitch_time_shifter #(
   parameter int unsigned BUFFER_DEPTH = gpts_pkg::BUFFER_DEPTH_DEF,
   parameter int unsigned GRAIN_LENGTH = gpts_pkg::GRAIN_LENGTH_DEF,
   parameter int unsigned GRAIN_SLOTS  = gpts_pkg::GRAIN_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gpts_req_if.sink                             req,
   gpts_rsp_if.source                           rsp,
   input  logic                                 csr_write_enable,
   input  gpts_pkg::csr_index_type              csr_index,
   input  logic [gpts_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import gpts_pkg::*;

   localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
   localparam int unsigned LW   = $clog2(GRAIN_LENGTH);
   localparam int unsigned SLW  = (GRAIN_SLOTS > 1) ? $clog2(GRAIN_SLOTS) : 1;
   localparam int unsigned SCW  = $clog2(GRAIN_SLOTS + 1);
   localparam int unsigned PW   = LW + 16;
   localparam int unsigned PRW  = PW + STEP_W;
   localparam int unsigned OW   = PRW - 32;
   localparam int unsigned RW   = (OW > AW + 1) ? OW : AW + 1;
   localparam int unsigned VW   = 34;
   localparam int unsigned TW   = VW + 17;
   localparam int unsigned SUMW = TW + SLW;
   localparam longint unsigned KNUM = longint'(GRAIN_LENGTH - 1) * 65536;
   localparam logic [PW-1:0] KQ = PW'(KNUM / GRAIN_LENGTH);
   localparam logic [LW:0]   KR = (LW+1)'(KNUM % GRAIN_LENGTH);
   localparam logic [AW:0]   DEPTH_V = (AW+1)'(BUFFER_DEPTH);
   localparam logic [RW-1:0] DEPTH_R = RW'(BUFFER_DEPTH);
   localparam logic [AW-1:0] BACK =
      AW'((2 * GRAIN_LENGTH) % BUFFER_DEPTH);
   localparam logic [LW:0]   GLEN = (LW+1)'(GRAIN_LENGTH);
   localparam logic [SCW-1:0] SLOTS_V = SCW'(GRAIN_SLOTS);

   state_type state_ff, state_in;

   logic                    en_ff, en_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [HOP_W-1:0]        hop_len_ff, hop_len_in;
   logic [HOP_COUNT_W-1:0]  hop_ff, hop_in;
   logic [AW-1:0]           wi_ff, wi_in;
   logic                    wrap_ff, wrap_in;
   logic signed [15:0]      sample_ff, sample_in;

   logic                    act_ff [GRAIN_SLOTS];
   logic                    act_in [GRAIN_SLOTS];
   logic [AW-1:0]           start_ff [GRAIN_SLOTS];
   logic [AW-1:0]           start_in [GRAIN_SLOTS];
   logic [LW:0]             age_ff [GRAIN_SLOTS];
   logic [LW:0]             age_in [GRAIN_SLOTS];
   logic [PW-1:0]           p_ff [GRAIN_SLOTS];
   logic [PW-1:0]           p_in [GRAIN_SLOTS];
   logic [LW:0]             r_ff [GRAIN_SLOTS];
   logic [LW:0]             r_in [GRAIN_SLOTS];

   logic [SCW-1:0]          g_ff, g_in;
   logic [PRW-1:0]          prod_ff, prod_in;
   logic [RW-1:0]           oi_ff, oi_in;
   logic [15:0]             frac_ff, frac_in;
   logic [AW-1:0]           pos_ff, pos_in;
   logic signed [15:0]      s0_ff, s0_in;
   logic signed [15:0]      s1_ff, s1_in;
   logic signed [VW-1:0]    t0_ff, t0_in;
   logic signed [VW-1:0]    v_ff, v_in;
   logic signed [TW-1:0]    term_ff, term_in;
   logic signed [SUMW-1:0]  sum_ff, sum_in;
   logic signed [15:0]      res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]      rsp_data_ff, rsp_data_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_ra;
   logic [15:0]             mem_rd;
   logic [15:0]             hann;

   logic [SLW-1:0]          gi;
   logic [SLW-1:0]          free_slot;
   logic [AW-1:0]           nxt;
   logic [AW:0]             pos_sum;
   logic [AW:0]             wi_inc;
   logic [AW:0]             start_sum;
   logic [LW+1:0]           r_sum;
   logic signed [SUMW-1:0]  sum_adj;
   logic signed [SUMW-32:0] quot;

   function automatic logic is_written(logic [AW-1:0] addr, logic [AW-1:0] wi,
                                       logic wrapped);
      return wrapped || (addr <= wi);
   endfunction

   assign gi = g_ff[SLW-1:0];

   gpts_delay_mem #(
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wi_ff),
      .wr_data (req.in_sample),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   gpts_hann_rom #(
      .GRAIN_LENGTH (GRAIN_LENGTH),
      .IW           (LW)
   ) u_rom (
      .clock    (clock),
      .rd_index (p_ff[gi][PW-1:16]),
      .rd_data  (hann)
   );

   always_comb begin
      free_slot = '0;
      for (int i = GRAIN_SLOTS - 1; i >= 0; i--) begin
         if (!act_ff[i]) free_slot = SLW'(i);
      end
   end

   assign nxt       = ({1'b0, pos_ff} + 1'b1 == DEPTH_V) ? '0 : pos_ff + 1'b1;
   assign pos_sum   = {1'b0, start_ff[gi]} + oi_ff[AW:0];
   assign wi_inc    = {1'b0, wi_ff} + 1'b1;
   assign start_sum = {1'b0, wi_ff} + DEPTH_V - {1'b0, BACK};
   assign r_sum     = {1'b0, r_ff[gi]} + {1'b0, KR};
   assign sum_adj   = sum_ff + ((sum_ff < 0) ? SUMW'(32'h7FFF_FFFF) : '0);
   assign quot      = sum_adj[SUMW-1:31];

   always_comb begin
      state_in     = state_ff;
      en_in        = en_ff;
      step_in      = step_ff;
      hop_len_in   = hop_len_ff;
      hop_in       = hop_ff;
      wi_in        = wi_ff;
      wrap_in      = wrap_ff;
      sample_in    = sample_ff;
      act_in       = act_ff;
      start_in     = start_ff;
      age_in       = age_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      g_in         = g_ff;
      prod_in      = prod_ff;
      oi_in        = oi_ff;
      frac_in      = frac_ff;
      pos_in       = pos_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      t0_in        = t0_ff;
      v_in         = v_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      mem_we       = 1'b0;
      mem_ra       = pos_ff;
      req.ready    = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:    en_in      = csr_write_data[0];
            CSR_READ_STEP: step_in    = csr_write_data[STEP_W-1:0];
            CSR_HOP:       hop_len_in = csr_write_data[HOP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               mem_we    = 1'b1;
               sample_in = req.in_sample;
               g_in      = '0;
               sum_in    = '0;
               if (!en_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
                  hop_in   = hop_ff + 1'b1;
                  if (hop_ff + 1'b1 >= {1'b0, hop_len_ff}) begin
                     hop_in              = '0;
                     act_in[free_slot]   = 1'b1;
                     age_in[free_slot]   = '0;
                     p_in[free_slot]     = '0;
                     r_in[free_slot]     = '0;
                     start_in[free_slot] = (start_sum >= DEPTH_V) ?
                        AW'(start_sum - DEPTH_V) : start_sum[AW-1:0];
                  end
               end
            end
         end
         ST_SCAN: begin
            if (g_ff == SLOTS_V) begin
               state_in = ST_FINISH;
            end else if (!act_ff[gi]) begin
               g_in = g_ff + 1'b1;
            end else if (age_ff[gi] >= GLEN) begin
               act_in[gi] = 1'b0;
               g_in       = g_ff + 1'b1;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PRW'(p_ff[gi]) * PRW'(step_ff);
            state_in = ST_OFFS;
         end
         ST_OFFS: begin
            oi_in    = RW'(prod_ff[PRW-1:32]);
            frac_in  = prod_ff[31:16];
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (oi_ff >= DEPTH_R) begin
               oi_in = oi_ff - DEPTH_R;
            end else begin
               pos_in   = (pos_sum >= DEPTH_V) ? AW'(pos_sum - DEPTH_V)
                                               : pos_sum[AW-1:0];
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            mem_ra   = pos_ff;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            mem_ra   = nxt;
            s0_in    = is_written(pos_ff, wi_ff, wrap_ff) ? mem_rd : '0;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            s1_in    = is_written(nxt, wi_ff, wrap_ff) ? mem_rd : '0;
            t0_in    = VW'(s0_ff * $signed({1'b0, 17'd65536 - {1'b0, frac_ff}}));
            state_in = ST_LERP;
         end
         ST_LERP: begin
            v_in     = t0_ff + VW'(s1_ff * $signed({1'b0, frac_ff}));
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            term_in  = v_ff * $signed({1'b0, hann});
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in     = sum_ff + SUMW'(term_ff);
            age_in[gi] = age_ff[gi] + 1'b1;
            if (r_sum >= {1'b0, GLEN}) begin
               r_in[gi] = (LW+1)'(r_sum - {1'b0, GLEN});
               p_in[gi] = p_ff[gi] + KQ + 1'b1;
            end else begin
               r_in[gi] = r_sum[LW:0];
               p_in[gi] = p_ff[gi] + KQ;
            end
            if (age_ff[gi] + 1'b1 >= GLEN) act_in[gi] = 1'b0;
            g_in     = g_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_FINISH: begin
            if (!en_ff) begin
               res_in = sample_ff;
            end else if (quot > $signed(17'sd32767)) begin
               res_in = 16'sh7FFF;
            end else if (quot < -$signed(18'sd32768)) begin
               res_in = -16'sh8000;
            end else begin
               res_in = quot[15:0];
            end
            if (wi_inc == DEPTH_V) begin
               wi_in   = '0;
               wrap_in = 1'b1;
            end else begin
               wi_in = wi_inc[AW-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= 1'b0;
         step_ff      <= STEP_W'(65536);
         hop_len_ff   <= HOP_W'(128);
         hop_ff       <= '0;
         wi_ff        <= '0;
         wrap_ff      <= 1'b0;
         g_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < GRAIN_SLOTS; i++) begin
            act_ff[i]   <= 1'b0;
            start_ff[i] <= '0;
            age_ff[i]   <= '0;
            p_ff[i]     <= '0;
            r_ff[i]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         step_ff      <= step_in;
         hop_len_ff   <= hop_len_in;
         hop_ff       <= hop_in;
         wi_ff        <= wi_in;
         wrap_ff      <= wrap_in;
         g_ff         <= g_in;
         rsp_valid_ff <= rsp_valid_in;
         act_ff       <= act_in;
         start_ff     <= start_in;
         age_ff       <= age_in;
         p_ff         <= p_in;
         r_ff         <= r_in;
      end
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      oi_ff       <= oi_in;
      frac_ff     <= frac_in;
      pos_ff      <= pos_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      t0_ff       <= t0_in;
      v_ff        <= v_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_sample = rsp_data_ff;

endmodule
